@@ hw/rtl/pdir_pkg.sv @@
// ----------------------------------------------------------------------------
// pdir_pkg - shared definitions for the pulse-distance IR receiver
// Widths, register indexes, reset values, payload types and the checksum check.
// ----------------------------------------------------------------------------
package pdir_pkg;

   localparam int unsigned PACKET_BITS = 32;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned REG_W   = 16;
   localparam int unsigned INDEX_W = 3;

   // bit count at which a frame is complete: leader plus every data bit
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(PACKET_BITS + 1);

   localparam logic [INDEX_W-1:0] REG_LEADER_MIN = 3'd0;
   localparam logic [INDEX_W-1:0] REG_LEADER_MAX = 3'd1;
   localparam logic [INDEX_W-1:0] REG_ONE_MIN    = 3'd2;
   localparam logic [INDEX_W-1:0] REG_ONE_MAX    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_ZERO_MIN   = 3'd4;
   localparam logic [INDEX_W-1:0] REG_ZERO_MAX   = 3'd5;

   localparam logic [REG_W-1:0] LEADER_MIN_RST = 16'd10800;
   localparam logic [REG_W-1:0] LEADER_MAX_RST = 16'd16875;
   localparam logic [REG_W-1:0] ONE_MIN_RST    = 16'd1800;
   localparam logic [REG_W-1:0] ONE_MAX_RST    = 16'd2812;
   localparam logic [REG_W-1:0] ZERO_MIN_RST   = 16'd896;
   localparam logic [REG_W-1:0] ZERO_MAX_RST   = 16'd1400;

   localparam logic MODE_LEVEL = 1'b0;
   localparam logic MODE_TAKE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic              pin_level;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  packet;
      logic               data_ready;
      logic               checksum_ok;
      logic [COUNT_W-1:0] bit_count;
   } rsp_type;

   // top byte must match the XOR-mask fold of the lower 24 bits of the packet
   function automatic logic checksum_check(input logic [DATA_W-1:0] raw);
      logic [31:0] c;
      logic [7:0]  fold;
      c = ((raw << 2) & 32'h0203_FDFC) ^
          ((raw << 1) & 32'h01FE_01FE) ^
          (raw        & 32'h0003_FFFF) ^
          ((raw >> 1) & 32'h0002_0000) ^
          ((raw >> 2) & 32'h0001_FC00) ^
          ((raw >> 3) & 32'h0003_FE00) ^
          ((raw >> 4) & 32'h000E_03FC) ^
          ((raw >> 5) & 32'h0003_FE02);
      fold = c[7:0] ^ c[15:8] ^ c[23:16] ^ c[31:24];
      return raw[31:24] == fold;
   endfunction

endpackage

@@ hw/rtl/pdir_req_if.sv @@
// ----------------------------------------------------------------------------
// pdir_req_if - event channel of the IR receiver
// Valid/ready channel carrying one timestamped pin event or take command.
// ----------------------------------------------------------------------------
interface pdir_req_if import pdir_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              mode;
   logic              pin_level;
   logic [TIME_W-1:0] time_us;

   modport source (output valid, output mode, output pin_level, output time_us,
                   input ready);
   modport sink   (input valid, input mode, input pin_level, input time_us,
                   output ready);
endinterface

@@ hw/rtl/pdir_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pdir_rsp_if - result channel of the IR receiver
// Valid/ready channel carrying the frame status after each event.
// ----------------------------------------------------------------------------
interface pdir_rsp_if import pdir_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  packet;
   logic               data_ready;
   logic               checksum_ok;
   logic [COUNT_W-1:0] bit_count;

   modport source (output valid, output packet, output data_ready,
                   output checksum_ok, output bit_count, input ready);
   modport sink   (input valid, input packet, input data_ready,
                   input checksum_ok, input bit_count, output ready);
endinterface

@@ hw/rtl/pulse_distance_ir_receiver.sv @@
// ----------------------------------------------------------------------------
// pulse_distance_ir_receiver - pulse-distance IR frame decoder
// Decodes timestamped events from an inverted IR line into a checked packet.
// ----------------------------------------------------------------------------
// Each transfer on req is one pin-level event (mode 0) or a take command
// (mode 1) and yields exactly one transfer on rsp, in order. The block takes
// one event per clock while the skid entry is empty and registers each
// result: the whole decode (gap subtraction, six window compares, shift and
// count) sits in a single stage ahead of the output register, and a skid
// entry keeps req open for one more event while rsp is stalled. The user
// writes window registers via csr_wr_en/csr_index/csr_wdata only while no
// event is outstanding (not enforced); writes past the last index are dropped.
module pulse_distance_ir_receiver import pdir_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   pdir_req_if.sink           req,
   pdir_rsp_if.source         rsp,
   input  logic               csr_wr_en,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]   csr_wdata
);

   req_type req_data;
   rsp_type core_rsp;
   rsp_type out_data;
   logic    req_fire;

   assign req_data.mode      = req.mode;
   assign req_data.pin_level = req.pin_level;
   assign req_data.time_us   = req.time_us;
   assign req_fire           = req.valid && req.ready;

   pdir_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (req_fire),
      .req       (req_data),
      .rsp       (core_rsp)
   );

   pdir_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (core_rsp),
      .push_ready (req.ready),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_data   (out_data)
   );

   assign rsp.packet      = out_data.packet;
   assign rsp.data_ready  = out_data.data_ready;
   assign rsp.checksum_ok = out_data.checksum_ok;
   assign rsp.bit_count   = out_data.bit_count;

endmodule

@@ hw/rtl/pdir_core.sv @@
// ----------------------------------------------------------------------------
// pdir_core - frame decoder state and window registers
// Times falling edges, classifies the gap and shifts bits into the frame.
// ----------------------------------------------------------------------------
module pdir_core import pdir_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]   csr_wdata,
   input  logic               fire,
   input  req_type            req,
   output rsp_type            rsp
);

   logic [REG_W-1:0] leader_min_ff, leader_max_ff;
   logic [REG_W-1:0] one_min_ff, one_max_ff;
   logic [REG_W-1:0] zero_min_ff, zero_max_ff;

   logic               last_level_ff, last_level_in;
   logic [TIME_W-1:0]  last_edge_ff, last_edge_in;
   logic [DATA_W-1:0]  shift_ff, shift_in, evt_shift;
   logic [COUNT_W-1:0] bits_ff, bits_in, evt_bits, bits_inc;
   logic               ready_ff, ready_in, evt_ready;

   logic [TIME_W-1:0] delta;
   logic              hit_leader, hit_one, hit_zero;

   assign delta    = req.time_us - last_edge_ff;
   assign bits_inc = bits_ff + COUNT_W'(1);

   assign hit_leader = (delta > TIME_W'(leader_min_ff)) && (delta < TIME_W'(leader_max_ff));
   assign hit_one    = (delta > TIME_W'(one_min_ff))    && (delta < TIME_W'(one_max_ff));
   assign hit_zero   = (delta > TIME_W'(zero_min_ff))   && (delta < TIME_W'(zero_max_ff));

   always_comb begin
      last_level_in = last_level_ff;
      last_edge_in  = last_edge_ff;
      evt_shift     = shift_ff;
      evt_bits      = bits_ff;
      evt_ready     = ready_ff;
      if (req.mode == MODE_LEVEL && !ready_ff && req.pin_level != last_level_ff) begin
         last_level_in = req.pin_level;
         if (!req.pin_level) begin
            last_edge_in = req.time_us;
            // leader wins over any bit window and re-arms mid-frame
            if (hit_leader) begin
               evt_bits  = COUNT_W'(1);
               evt_shift = '0;
            end else if (bits_ff != '0 && (hit_one || hit_zero)) begin
               evt_shift = {hit_one, shift_ff[DATA_W-1:1]};
               evt_bits  = bits_inc;
               evt_ready = (bits_inc == FULL_COUNT);
            end
         end
      end

      rsp.packet      = evt_shift;
      rsp.data_ready  = evt_ready;
      rsp.checksum_ok = checksum_check(evt_shift);
      rsp.bit_count   = evt_bits;

      // take reports the frame, then drops it
      if (req.mode == MODE_TAKE) begin
         shift_in = '0;
         bits_in  = '0;
         ready_in = 1'b0;
      end else begin
         shift_in = evt_shift;
         bits_in  = evt_bits;
         ready_in = evt_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_min_ff <= LEADER_MIN_RST;
         leader_max_ff <= LEADER_MAX_RST;
         one_min_ff    <= ONE_MIN_RST;
         one_max_ff    <= ONE_MAX_RST;
         zero_min_ff   <= ZERO_MIN_RST;
         zero_max_ff   <= ZERO_MAX_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LEADER_MIN: leader_min_ff <= csr_wdata;
            REG_LEADER_MAX: leader_max_ff <= csr_wdata;
            REG_ONE_MIN:    one_min_ff    <= csr_wdata;
            REG_ONE_MAX:    one_max_ff    <= csr_wdata;
            REG_ZERO_MIN:   zero_min_ff   <= csr_wdata;
            REG_ZERO_MAX:   zero_max_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         last_edge_ff  <= '0;
         shift_ff      <= '0;
         bits_ff       <= '0;
         ready_ff      <= 1'b0;
      end else if (fire) begin
         last_level_ff <= last_level_in;
         last_edge_ff  <= last_edge_in;
         shift_ff      <= shift_in;
         bits_ff       <= bits_in;
         ready_ff      <= ready_in;
      end
   end

endmodule

@@ hw/rtl/pdir_out_buf.sv @@
// ----------------------------------------------------------------------------
// pdir_out_buf - two-entry result buffer
// Output register plus skid register so input stays open while a result waits.
// ----------------------------------------------------------------------------
module pdir_out_buf import pdir_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    drain;

   assign push_ready = !skid_valid_ff;
   assign drain      = out_valid_ff && out_ready;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || drain) begin
         // advance the skid entry first; no push can land while it is full
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

@@ hw/rtl/pdir_checker.sv @@
// ----------------------------------------------------------------------------
// pdir_checker - port-level checks for the IR receiver
// Watches the result channel for handshake and frame-status consistency.
// ----------------------------------------------------------------------------
module pdir_checker import pdir_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DATA_W-1:0]  rsp_packet,
   input logic               rsp_data_ready,
   input logic               rsp_checksum_ok,
   input logic [COUNT_W-1:0] rsp_bit_count
);

   // hold a stalled result until its transfer
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_packet) && $stable(rsp_data_ready)
                                  && $stable(rsp_checksum_ok) && $stable(rsp_bit_count))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // an unarmed frame always holds an empty shift register
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_count == '0 |-> rsp_packet == '0 && !rsp_data_ready)
      else $error("idle frame with data");

   a_ready_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_ready |-> rsp_bit_count == FULL_COUNT)
      else $error("frame ready without full bit count");

endmodule

bind pulse_distance_ir_receiver pdir_checker u_pdir_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_packet      (rsp.packet),
   .rsp_data_ready  (rsp.data_ready),
   .rsp_checksum_ok (rsp.checksum_ok),
   .rsp_bit_count   (rsp.bit_count)
);

@@ tb/pulse_distance_ir_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// pulse_distance_ir_receiver_tb - self-checking bench for the IR frame decoder
// Streams timestamped pin events and take commands through the req channel,
// predicts every rsp transfer and compares field by field. Window registers
// are changed between phases only while the block is drained.
// ----------------------------------------------------------------------------
module pulse_distance_ir_receiver_tb;
   import pdir_pkg::*;

   typedef enum {FRAME_CLEAN, FRAME_BAD_GAP, FRAME_RELEADER} frame_kind_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [INDEX_W-1:0] csr_index;
   logic [REG_W-1:0]   csr_wdata;

   pdir_req_if req_if ();
   pdir_rsp_if rsp_if ();

   pulse_distance_ir_receiver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder state as the bench sees it
   logic [REG_W-1:0]   window_reg [0:5];
   logic               line_last  = 1'b0;
   logic [TIME_W-1:0]  edge_last  = '0;
   logic [DATA_W-1:0]  shift_reg  = '0;
   logic [COUNT_W-1:0] bit_cnt    = '0;
   logic               frame_held = 1'b0;

   req_type     event_q [$];
   rsp_type     status_q [$];
   req_type     next_ev;
   rsp_type     want;
   int unsigned send_gap, send_calm, recv_gap, recv_calm;
   int          error_count = 0;
   logic [TIME_W-1:0] line_time = '0;

   function automatic logic [7:0] check_byte(input logic [DATA_W-1:0] raw);
      logic [31:0] mix;
      mix = ((raw << 2) & 32'h0203_FDFC) ^ ((raw << 1) & 32'h01FE_01FE) ^
            (raw & 32'h0003_FFFF) ^ ((raw >> 1) & 32'h0002_0000) ^
            ((raw >> 2) & 32'h0001_FC00) ^ ((raw >> 3) & 32'h0003_FE00) ^
            ((raw >> 4) & 32'h000E_03FC) ^ ((raw >> 5) & 32'h0003_FE02);
      return mix[31:24] ^ mix[23:16] ^ mix[15:8] ^ mix[7:0];
   endfunction

   function automatic bit in_span(input logic [TIME_W-1:0] t,
                                  input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
      return t > TIME_W'(lo) && t < TIME_W'(hi);
   endfunction

   function automatic rsp_type decode_event(input req_type ev);
      rsp_type           st;
      logic [TIME_W-1:0] gap;
      logic              hit;
      logic              bit_val;
      hit = 1'b0;
      bit_val = 1'b0;
      if (ev.mode == MODE_LEVEL && !frame_held && ev.pin_level != line_last) begin
         line_last = ev.pin_level;
         if (!ev.pin_level) begin
            gap = ev.time_us - edge_last;
            edge_last = ev.time_us;
            if (in_span(gap, window_reg[REG_LEADER_MIN], window_reg[REG_LEADER_MAX])) begin
               // leader re-arms even in the middle of a frame
               bit_cnt = COUNT_W'(1);
               shift_reg = '0;
            end else if (bit_cnt != '0) begin
               if (in_span(gap, window_reg[REG_ONE_MIN], window_reg[REG_ONE_MAX])) begin
                  hit = 1'b1;
                  bit_val = 1'b1;
               end else if (in_span(gap, window_reg[REG_ZERO_MIN],
                                    window_reg[REG_ZERO_MAX])) begin
                  hit = 1'b1;
               end
               if (hit) begin
                  shift_reg = {bit_val, shift_reg[DATA_W-1:1]};
                  bit_cnt = bit_cnt + COUNT_W'(1);
                  if (bit_cnt == FULL_COUNT) frame_held = 1'b1;
               end
            end
         end
      end
      st.packet      = shift_reg;
      st.data_ready  = frame_held;
      st.checksum_ok = shift_reg[31:24] == check_byte(shift_reg);
      st.bit_count   = bit_cnt;
      if (ev.mode == MODE_TAKE) begin
         shift_reg = '0;
         bit_cnt = '0;
         frame_held = 1'b0;
      end
      return st;
   endfunction

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int unsigned pick_idle(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 80);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic compare_field(input string what, input logic [31:0] exp_val,
                                input logic [31:0] got);
      if (got !== exp_val) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_val, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            status_q.push_back(decode_event({req_if.mode, req_if.pin_level, req_if.time_us}));
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (event_q.size() > 0) begin
               next_ev = event_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.mode      <= next_ev.mode;
               req_if.pin_level <= next_ev.pin_level;
               req_if.time_us   <= next_ev.time_us;
               send_gap = pick_idle(send_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap = 0;
         recv_calm = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: unexpected result: packet %h ready %b count %0d", $time,
                        rsp_if.packet, rsp_if.data_ready, rsp_if.bit_count);
               error_count++;
            end else begin
               want = status_q.pop_front();
               compare_field("packet", want.packet, rsp_if.packet);
               compare_field("data_ready", 32'(want.data_ready), 32'(rsp_if.data_ready));
               compare_field("checksum_ok", 32'(want.checksum_ok),
                             32'(rsp_if.checksum_ok));
               compare_field("bit_count", 32'(want.bit_count), 32'(rsp_if.bit_count));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_gap = pick_idle(recv_calm);
         end
      end
   end

   task automatic push_event(input logic mode, input logic lvl, input logic [TIME_W-1:0] t);
      req_type ev;
      ev.mode = mode;
      ev.pin_level = lvl;
      ev.time_us = t;
      event_q.push_back(ev);
   endtask

   // rise halfway, fall at the end of the period
   task automatic push_period(input logic [TIME_W-1:0] period);
      push_event(MODE_LEVEL, 1'b1, line_time + period / 2);
      line_time = line_time + period;
      push_event(MODE_LEVEL, 1'b0, line_time);
   endtask

   function automatic logic [TIME_W-1:0] pick_inside(input logic [REG_W-1:0] lo,
                                                     input logic [REG_W-1:0] hi);
      int unsigned l;
      int unsigned h;
      l = 32'(lo);
      h = 32'(hi);
      if (h > l + 1) return $urandom_range(l + 1, h - 1);
      return l;
   endfunction

   // near misses around window bounds, short gaps and wild jumps
   function automatic logic [TIME_W-1:0] noise_period();
      int unsigned      r;
      logic [REG_W-1:0] bound;
      r = $urandom_range(0, 9);
      if (r < 2) return $urandom;
      if (r < 4) return $urandom_range(0, 200);
      bound = window_reg[INDEX_W'($urandom_range(32'(REG_LEADER_MIN), 32'(REG_ZERO_MAX)))];
      return TIME_W'(bound) + $urandom_range(0, 2) - 1;
   endfunction

   task automatic push_frame(input logic [DATA_W-1:0] data, input int unsigned nbits,
                             input frame_kind_type kind);
      int unsigned slot;
      slot = $urandom_range(0, nbits - 1);
      if ($urandom_range(0, 9) == 0) line_time = 32'hFFFF_FFFF - $urandom_range(0, 60000);
      // force a fresh falling edge to time the leader from
      push_event(MODE_LEVEL, 1'b1, line_time);
      push_event(MODE_LEVEL, 1'b0, line_time);
      push_period(pick_inside(window_reg[REG_LEADER_MIN], window_reg[REG_LEADER_MAX]));
      for (int unsigned i = 0; i < nbits; i++) begin
         if (i == slot && kind == FRAME_BAD_GAP) push_period(noise_period());
         if (i == slot && kind == FRAME_RELEADER)
            push_period(pick_inside(window_reg[REG_LEADER_MIN], window_reg[REG_LEADER_MAX]));
         if (data[i])
            push_period(pick_inside(window_reg[REG_ONE_MIN], window_reg[REG_ONE_MAX]));
         else
            push_period(pick_inside(window_reg[REG_ZERO_MIN], window_reg[REG_ZERO_MAX]));
      end
   endtask

   task automatic push_noise(input int unsigned count);
      repeat (count) begin
         line_time = line_time + noise_period();
         push_event(MODE_LEVEL, 1'($urandom_range(0, 1)), line_time);
      end
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= REG_W'(value);
      window_reg[idx] = REG_W'(value);
   endtask

   task automatic write_windows(input int unsigned lmin, input int unsigned lmax,
                                input int unsigned omin, input int unsigned omax,
                                input int unsigned zmin, input int unsigned zmax);
      write_reg(REG_LEADER_MIN, lmin);
      write_reg(REG_LEADER_MAX, lmax);
      write_reg(REG_ONE_MIN, omin);
      write_reg(REG_ONE_MAX, omax);
      write_reg(REG_ZERO_MIN, zmin);
      write_reg(REG_ZERO_MAX, zmax);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (event_q.size() != 0 || req_if.valid || status_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : stimulus
      int unsigned       budget;
      int unsigned       r;
      int unsigned       zl, zh, ol, oh, ll, lh;
      logic [DATA_W-1:0] data;
      frame_kind_type    kind;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.mode      = MODE_LEVEL;
      req_if.pin_level = 1'b0;
      req_if.time_us   = '0;
      rsp_if.ready     = 1'b0;
      window_reg[REG_LEADER_MIN] = LEADER_MIN_RST;
      window_reg[REG_LEADER_MAX] = LEADER_MAX_RST;
      window_reg[REG_ONE_MIN]    = ONE_MIN_RST;
      window_reg[REG_ONE_MAX]    = ONE_MAX_RST;
      window_reg[REG_ZERO_MIN]   = ZERO_MIN_RST;
      window_reg[REG_ZERO_MAX]   = ZERO_MAX_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through the window bounds with reset windows
      push_event(MODE_LEVEL, 1'b1, 32'd0);                 // rising edge only
      push_event(MODE_LEVEL, 1'b1, 32'd5);                 // same level
      push_event(MODE_LEVEL, 1'b0, 32'd1000);              // fall while not armed
      push_event(MODE_LEVEL, 1'b1, 32'd1500);
      push_event(MODE_LEVEL, 1'b0, 32'd11800);             // leader lower bound itself
      push_event(MODE_LEVEL, 1'b1, 32'd12000);
      push_event(MODE_LEVEL, 1'b0, 32'd22601);             // just inside: arm
      push_event(MODE_LEVEL, 1'b1, 32'd23000);
      push_event(MODE_LEVEL, 1'b0, 32'd25413);             // one upper bound: no window
      push_event(MODE_LEVEL, 1'b1, 32'd25500);
      push_event(MODE_LEVEL, 1'b0, 32'd28224);             // one
      push_event(MODE_LEVEL, 1'b1, 32'd28500);
      push_event(MODE_LEVEL, 1'b0, 32'd29121);             // zero
      push_event(MODE_LEVEL, 1'b1, 32'd29200);
      push_event(MODE_LEVEL, 1'b0, 32'd45995);             // leader again mid-frame
      push_event(MODE_TAKE, 1'b0, 32'd0);                  // take mid-frame
      push_event(MODE_TAKE, 1'b1, 32'hFFFF_FFFF);          // take with nothing held
      push_event(MODE_LEVEL, 1'b1, 32'hFFFF_F000);
      push_event(MODE_LEVEL, 1'b0, 32'hFFFF_F100);
      push_event(MODE_LEVEL, 1'b1, 32'hFFFF_F200);
      push_event(MODE_LEVEL, 1'b0, 32'hFFFF_F100 + 32'd13500); // leader across the wrap
      push_event(MODE_LEVEL, 1'b1, 32'hFFFF_F100 + 32'd13600);
      push_event(MODE_LEVEL, 1'b0, 32'hFFFF_F100 + 32'd14620); // zero
      push_event(MODE_TAKE, 1'b0, 32'h8000_0000);
      line_time = 32'hFFFF_F100 + 32'd14620;
      wait_drained();

      for (int unsigned phase = 0; phase < 11; phase++) begin
         budget = 100;
         case (phase)
            0: write_windows(10800, 16875, 1800, 2812, 896, 1400);
            1: write_windows(9000, 20000, 1000, 2000, 600, 1500);     // one over zero
            2: write_windows(60000, 65535, 0, 300, 300, 600);
            3: begin
               write_windows(0, 0, 0, 0, 0, 0);
               budget = 40;
            end
            4: begin
               write_windows(65535, 65535, 65535, 65535, 65535, 65535);
               budget = 40;
            end
            default: begin
               zl = $urandom_range(0, 3000);
               zh = zl + $urandom_range(2, 2000);
               ol = ($urandom_range(0, 3) == 0) ? zl : zh + $urandom_range(0, 2000);
               oh = ol + $urandom_range(2, 3000);
               ll = oh + $urandom_range(0, 20000);
               lh = ll + $urandom_range(2, 20000);
               write_windows(ll, lh, ol, oh, zl, zh);
            end
         endcase
         if (phase < 3) budget = 110;
         while (event_q.size() < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               data = $urandom;
               if ($urandom_range(0, 1)) data[31:24] = check_byte(data);
               r = $urandom_range(0, 99);
               kind = (r < 75) ? FRAME_CLEAN : (r < 88) ? FRAME_BAD_GAP : FRAME_RELEADER;
               push_frame(data, ($urandom_range(0, 6) == 0) ? $urandom_range(1, 31) : 32, kind);
               // sometimes keep poking the line while the frame is held
               if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 6));
               push_event(MODE_TAKE, 1'($urandom_range(0, 1)), $urandom);
            end else if (r < 90) begin
               push_noise(4);
            end else begin
               push_event(MODE_TAKE, 1'($urandom_range(0, 1)), $urandom);
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout: %0d events pending, %0d results outstanding",
               event_q.size(), status_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ pulse_distance_ir_receiver.f @@
hw/rtl/pdir_pkg.sv
hw/rtl/pdir_req_if.sv
hw/rtl/pdir_rsp_if.sv
hw/rtl/pdir_core.sv
hw/rtl/pdir_out_buf.sv
hw/rtl/pulse_distance_ir_receiver.sv
hw/rtl/pdir_checker.sv
tb/pulse_distance_ir_receiver_tb.sv
